// ===== rtl/lslf_pkg.sv =====
// Package for the least-squares line fit block.
// Holds the request/result payload types, status codes and sequencer states.
// No dependencies.
package lslf_pkg;

	localparam int SAMPLE_W = 24;
	localparam int RESULT_W = 32;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} lslf_req_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] slope;
		logic signed [RESULT_W-1:0] intercept;
		logic [1:0]                 status;
	} lslf_fit_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	localparam logic [RESULT_W-1:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [RESULT_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef enum logic [2:0] {
		S_ACC,
		S_MLOAD,
		S_MUL,
		S_DLOAD,
		S_DIV,
		S_RND,
		S_SAT,
		S_DONE
	} lslf_state_t;

endpackage

// ===== rtl/least_squares_line_fit.sv =====
// Least-squares line fit over a window of samples, with serial multiply and divide.
// Depends on lslf_pkg.
//
// Usage: requests arrive on req (valid/ready), one sample each, numbered 0, 1, 2 ...
// The request with last set closes the window; one result then leaves on fit
// (valid/ready) carrying slope, intercept and status. Other requests give no result.
// Throughput: one sample per cycle while a window fills. After the last sample the
// fit runs in a shift-add multiplier that takes one multiplier bit per cycle
// (6 products of YW bits each) and a restoring divider that takes one quotient
// bit per cycle (two quotients), then loads the output register. req_ready is
// low until then. A single-sample or overlong window skips the arithmetic and
// goes straight to the done state, from which its result enters the output
// register once that register is free.
// The result sits in an output register; a stalled receiver holds the block only
// once the next window's result is ready to be written.
// Reset clears the sums, the sample count and the output valid; it takes effect
// at once and needs no clearing pass.
module least_squares_line_fit #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lslf_pkg::lslf_req_t req,
	output logic                fit_valid,
	input  logic                fit_ready,
	output lslf_pkg::lslf_fit_t fit
);
	import lslf_pkg::*;

	localparam longint unsigned MS   = longint'(MAX_SAMPLES);
	localparam longint unsigned AMAX = (MS - 1) * MS * (2 * MS - 1) / 6;
	localparam longint unsigned BMAX = (MS - 1) * MS / 2;
	localparam int IW   = $clog2(MAX_SAMPLES + 1);
	localparam int AW   = $clog2(AMAX + 1);
	localparam int BW   = $clog2(BMAX + 1);
	localparam int PRW  = IW + 1 + SAMPLE_W;
	localparam int CW0  = SAMPLE_W + BW + 1;
	localparam int CW   = (CW0 > PRW) ? CW0 : PRW;
	localparam int DW   = SAMPLE_W + IW;
	localparam int YW0  = (AW > BW) ? AW : BW;
	localparam int YW   = (YW0 > IW) ? YW0 : IW;
	localparam int PW0  = AW + CW + 2;
	localparam int PW   = (PW0 > RESULT_W + 2) ? PW0 : RESULT_W + 2;
	localparam int CTW  = $clog2(((PW > YW) ? PW : YW) + 1);

	lslf_state_t state_q, state_nxt;

	logic [IW-1:0]        idx_q;
	logic [AW-1:0]        a_q;
	logic [BW-1:0]        b_q;
	logic signed [CW-1:0] c_q;
	logic signed [DW-1:0] d_q;
	logic                 ovf_q;

	logic [2:0]           pass_q;
	logic [CTW-1:0]       cnt_q;
	logic signed [PW-1:0] acc_q;
	logic [PW-1:0]        mx_q;
	logic [YW-1:0]        my_q;
	logic [PW-1:0]        den_q;
	logic signed [PW-1:0] nums_q;
	logic                 dsel_q;
	logic                 dneg_q;
	logic [PW-1:0]        dq_q;
	logic [PW-1:0]        rem_q;
	logic [RESULT_W-1:0]  slope_q;
	logic [RESULT_W-1:0]  icept_q;
	logic [1:0]           status_q;
	lslf_fit_t            fit_q;
	logic                 fit_valid_q;

	logic                 req_fire;
	logic                 fit_load;
	logic                 room;
	logic [1:0]           win_status;
	logic [2*IW-1:0]      isq;
	logic signed [PRW-1:0] isp;
	logic                 cnt_end;
	logic signed [PW-1:0] dnum;
	logic [PW:0]          trial;
	logic                 round_up;
	logic [PW-32:0]       qhi;
	logic                 qhi_zero;
	logic                 q_is_min;
	logic [RESULT_W-1:0]  sat_res;

	assign req_fire = req_valid && req_ready;
	assign room     = idx_q < IW'(MAX_SAMPLES);
	assign cnt_end  = cnt_q == CTW'(1);

	// Window state as seen when the last sample arrives, before it is counted
	always_comb begin
		if (ovf_q || !room)
			win_status = STATUS_TOO_LONG;
		else if (idx_q == '0)
			win_status = STATUS_ZERO_DEN;
		else
			win_status = STATUS_OK;
	end

	assign isq = (2*IW)'(idx_q) * (2*IW)'(idx_q);
	assign isp = $signed({1'b0, idx_q}) * req.sample;

	// Divider step and final rounding / saturation
	assign dnum     = dsel_q ? acc_q : nums_q;
	assign trial    = {rem_q, dq_q[PW-1]} - {1'b0, den_q};
	assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};
	assign qhi      = dq_q[PW-1:RESULT_W-1];
	assign qhi_zero = qhi == '0;
	assign q_is_min = (qhi == (PW-31)'(1)) && (dq_q[RESULT_W-2:0] == '0);

	always_comb begin
		if (dneg_q)
			sat_res = (qhi_zero || q_is_min) ? ~dq_q[RESULT_W-1:0] + 32'd1 : SAT_NEG;
		else
			sat_res = qhi_zero ? dq_q[RESULT_W-1:0] : SAT_POS;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_ACC: begin
				if (req_fire && req.last)
					state_nxt = (win_status == STATUS_OK) ? S_MLOAD : S_DONE;
			end
			S_MLOAD: state_nxt = S_MUL;
			S_MUL: begin
				if (cnt_end)
					state_nxt = (pass_q == 3'd5) ? S_DLOAD : S_MLOAD;
			end
			S_DLOAD: state_nxt = S_DIV;
			S_DIV: begin
				if (cnt_end)
					state_nxt = S_RND;
			end
			S_RND: state_nxt = S_SAT;
			S_SAT:  state_nxt = dsel_q ? S_DONE : S_DLOAD;
			S_DONE: begin
				if (fit_load)
					state_nxt = S_ACC;
			end
			default: state_nxt = S_ACC;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req_ready = state_q == S_ACC;
		fit_load  = (state_q == S_DONE) && (!fit_valid_q || fit_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			fit_valid_q <= 1'b0;
			idx_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			ovf_q       <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fit_load)
				fit_valid_q <= 1'b1;
			else if (fit_ready)
				fit_valid_q <= 1'b0;

			if (fit_load) begin
				idx_q <= '0;
				a_q   <= '0;
				b_q   <= '0;
				c_q   <= '0;
				d_q   <= '0;
				ovf_q <= 1'b0;
			end else if (req_fire) begin
				if (room) begin
					a_q   <= a_q + AW'(isq);
					b_q   <= b_q + BW'(idx_q);
					c_q   <= c_q + CW'(isp);
					d_q   <= d_q + DW'(req.sample);
					idx_q <= idx_q + IW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_ACC: begin
				if (req_fire && req.last) begin
					status_q <= win_status;
					slope_q  <= '0;
					icept_q  <= '0;
					pass_q   <= 3'd0;
					dsel_q   <= 1'b0;
				end
			end
			S_MLOAD: begin
				// even passes start a fresh sum; finished sums are kept aside
				if (!pass_q[0])
					acc_q <= '0;
				if (pass_q == 3'd2)
					den_q <= acc_q;
				if (pass_q == 3'd4)
					nums_q <= acc_q;
				cnt_q <= CTW'(YW);
				unique case (pass_q)
					3'd0: begin mx_q <= PW'(a_q); my_q <= YW'(idx_q); end
					3'd1: begin mx_q <= PW'(b_q); my_q <= YW'(b_q);   end
					3'd2: begin mx_q <= PW'(c_q); my_q <= YW'(idx_q); end
					3'd3: begin mx_q <= PW'(d_q); my_q <= YW'(b_q);   end
					3'd4: begin mx_q <= PW'(d_q); my_q <= YW'(a_q);   end
					3'd5: begin mx_q <= PW'(c_q); my_q <= YW'(b_q);   end
					default: begin mx_q <= '0; my_q <= '0; end
				endcase
			end
			S_MUL: begin
				if (my_q[0])
					acc_q <= pass_q[0] ? acc_q - mx_q : acc_q + mx_q;
				mx_q  <= {mx_q[PW-2:0], 1'b0};
				my_q  <= my_q >> 1;
				cnt_q <= cnt_q - CTW'(1);
				if (cnt_end)
					pass_q <= pass_q + 3'd1;
			end
			S_DLOAD: begin
				dneg_q <= dnum[PW-1];
				dq_q   <= dnum[PW-1] ? PW'(-dnum) : PW'(dnum);
				rem_q  <= '0;
				cnt_q  <= CTW'(PW);
			end
			S_DIV: begin
				if (!trial[PW]) begin
					rem_q <= trial[PW-1:0];
					dq_q  <= {dq_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[PW-2:0], dq_q[PW-1]};
					dq_q  <= {dq_q[PW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CTW'(1);
			end
			S_RND: begin
				// ties go away from zero: rounding is on the magnitude
				dq_q <= dq_q + PW'(round_up);
			end
			S_SAT: begin
				if (dsel_q)
					icept_q <= sat_res;
				else
					slope_q <= sat_res;
				dsel_q <= 1'b1;
			end
			S_DONE: begin
				if (fit_load) begin
					fit_q.slope     <= slope_q;
					fit_q.intercept <= icept_q;
					fit_q.status    <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign fit_valid = fit_valid_q;
	assign fit       = fit_q;

endmodule

// ===== test/tb.sv =====
// Testbench for least_squares_line_fit: random and directed sample windows, results
// checked field by field against an in-bench least-squares predictor.
// Depends on lslf_pkg and the least_squares_line_fit RTL.
`timescale 1ns / 1ps

module tb;
	import lslf_pkg::*;

	localparam int MAX_SAMPLES = 64;
	localparam int TARGET_ITEMS = 1550;
	// worst case is roughly 775 two-sample windows plus receiver stalls
	localparam int unsigned LIMIT_CYCLES = 2_000_000;
	localparam int TAIL_CYCLES = 300;
	localparam longint SMP_MAX = 64'sd8388607;
	localparam longint SMP_MIN = -64'sd8388608;
	localparam longint FIT_MAX = 64'sd2147483647;
	localparam longint FIT_MIN = -64'sd2147483648;

	typedef enum int {
		STY_RANDOM,
		STY_RAMP,
		STY_EXTREME,
		STY_SMALL
	} sample_style_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	lslf_req_t req = '0;
	logic      fit_valid;
	logic      fit_ready = 1'b0;
	lslf_fit_t fit;

	lslf_req_t sample_queue[$];
	lslf_fit_t fits_expected[$];

	// predictor state for the window being filled
	longint fill_count = 0;
	longint sum_ii = 0;
	longint sum_i = 0;
	longint sum_is = 0;
	longint sum_s = 0;
	bit     overflowed = 1'b0;

	int          total_items = 0;
	int          samples_accepted = 0;
	int          windows_seen = 0;
	int          zero_den_seen = 0;
	int          too_long_seen = 0;
	int          errors = 0;
	int unsigned cycle_count = 0;
	logic        req_taken = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	least_squares_line_fit #(.MAX_SAMPLES(MAX_SAMPLES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.fit_valid(fit_valid),
		.fit_ready(fit_ready),
		.fit(fit)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// thirds of the run: sender idles lightly, then heavily, then not at all
	function automatic int send_idle_pct();
		int phase;
		phase = (total_items == 0) ? 0 : samples_accepted * 3 / total_items;
		case (phase)
			0: return 18;
			1: return 54;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		int phase;
		phase = (total_items == 0) ? 0 : samples_accepted * 3 / total_items;
		case (phase)
			0: return 54;
			1: return 18;
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clamp_sample(longint v);
		if (v > SMP_MAX)
			return SMP_MAX[SAMPLE_W-1:0];
		if (v < SMP_MIN)
			return SMP_MIN[SAMPLE_W-1:0];
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [RESULT_W-1:0] round_div_sat(longint num, longint den);
		longint q;
		longint r;
		q = num / den;
		r = num % den;
		if (r < 0)
			r = -r;
		// nearest, ties away from zero
		if (2 * r >= den)
			q = (num < 0) ? q - 1 : q + 1;
		if (q > FIT_MAX)
			return SAT_POS;
		if (q < FIT_MIN)
			return SAT_NEG;
		return q[RESULT_W-1:0];
	endfunction

	// running sums per accepted request; the closing request yields one fit
	task automatic take_sample(lslf_req_t r);
		longint s;
		longint den;
		lslf_fit_t f;
		s = r.sample;
		if (fill_count < MAX_SAMPLES) begin
			sum_ii += fill_count * fill_count;
			sum_i += fill_count;
			sum_is += fill_count * s;
			sum_s += s;
			fill_count++;
		end else begin
			overflowed = 1'b1;
		end
		if (r.last) begin
			f.slope = '0;
			f.intercept = '0;
			f.status = STATUS_OK;
			if (overflowed) begin
				f.status = STATUS_TOO_LONG;
				too_long_seen++;
			end else begin
				den = fill_count * sum_ii - sum_i * sum_i;
				if (den <= 0) begin
					f.status = STATUS_ZERO_DEN;
					zero_den_seen++;
				end else begin
					f.slope = round_div_sat(fill_count * sum_is - sum_i * sum_s, den);
					f.intercept = round_div_sat(sum_ii * sum_s - sum_i * sum_is, den);
				end
			end
			fits_expected.insert(fits_expected.size(), f);
			windows_seen++;
			fill_count = 0;
			sum_ii = 0;
			sum_i = 0;
			sum_is = 0;
			sum_s = 0;
			overflowed = 1'b0;
		end
	endtask

	task automatic push_sample(longint v, bit is_last);
		lslf_req_t r;
		r.sample = clamp_sample(v);
		r.last = is_last;
		sample_queue.insert(sample_queue.size(), r);
		total_items++;
	endtask

	task automatic add_window(int len, sample_style_t style);
		longint base;
		longint step;
		longint span;
		longint v;
		logic signed [SAMPLE_W-1:0] raw;
		raw = SAMPLE_W'($urandom);
		base = raw;
		case ($urandom_range(2))
			0: span = 4;
			1: span = 4096;
			default: span = 1 << 18;
		endcase
		step = longint'($urandom_range(32'(2 * span))) - span;
		for (int i = 0; i < len; i++) begin
			case (style)
				STY_RANDOM: begin
					raw = SAMPLE_W'($urandom);
					v = raw;
				end
				STY_RAMP: v = base + step * i + longint'($urandom_range(64)) - 32;
				STY_EXTREME: v = $urandom_range(1) ? SMP_MAX : SMP_MIN;
				default: v = longint'($urandom_range(32)) - 16;
			endcase
			push_sample(v, i == len - 1);
		end
	endtask

	// driver: new request only once the previous one has gone
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
				req <= sample_queue.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// one long receiver hold-off late in the run, so the block backs up onto req
	always @(posedge clk) begin
		if (!hold_done && total_items > 0 && samples_accepted >= total_items * 5 / 6) begin
			hold_left <= 600;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			fit_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
	end

	always @(posedge clk) begin : watch
		lslf_fit_t want;
		req_taken <= arst_n && req_valid && req_ready;
		if (arst_n && fit_valid && fit_ready) begin
			if (fits_expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, fit);
				errors++;
			end else begin
				want = fits_expected.pop_front();
				if (fit.slope !== want.slope) begin
					$display("%0t: slope mismatch, expected %0d actual %0d",
						$time, want.slope, fit.slope);
					errors++;
				end
				if (fit.intercept !== want.intercept) begin
					$display("%0t: intercept mismatch, expected %0d actual %0d",
						$time, want.intercept, fit.intercept);
					errors++;
				end
				if (fit.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d",
						$time, want.status, fit.status);
					errors++;
				end
			end
		end
		if (arst_n && req_valid && req_ready) begin
			take_sample(req);
			samples_accepted++;
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d fits outstanding",
			cycle_count, fits_expected.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		int r;
		int len;
		// directed: single samples, extremes, flat and alternating windows
		push_sample(SMP_MAX, 1'b1);
		push_sample(0, 1'b1);
		push_sample(SMP_MIN, 1'b0);
		push_sample(SMP_MAX, 1'b1);
		push_sample(SMP_MAX, 1'b0);
		push_sample(SMP_MIN, 1'b1);
		for (int i = 0; i < 4; i++)
			push_sample(SMP_MAX, i == 3);
		for (int i = 0; i < 4; i++)
			push_sample(SMP_MIN, i == 3);
		push_sample(-1, 1'b0);
		push_sample(1, 1'b0);
		push_sample(-1, 1'b1);
		push_sample(0, 1'b0);
		push_sample(1, 1'b1);
		// full window, one past full, and well past full
		add_window(MAX_SAMPLES, STY_RAMP);
		add_window(MAX_SAMPLES + 1, STY_RANDOM);
		add_window(MAX_SAMPLES + 12, STY_EXTREME);
		while (total_items < TARGET_ITEMS) begin
			r = $urandom_range(99);
			if (r < 10)
				len = 1;
			else if (r < 75)
				len = $urandom_range(8, 2);
			else if (r < 92)
				len = $urandom_range(32, 9);
			else if (r < 97)
				len = $urandom_range(MAX_SAMPLES, 33);
			else
				len = $urandom_range(MAX_SAMPLES + 16, MAX_SAMPLES + 1);
			r = $urandom_range(99);
			if (r < 50)
				add_window(len, STY_RAMP);
			else if (r < 75)
				add_window(len, STY_RANDOM);
			else if (r < 87)
				add_window(len, STY_EXTREME);
			else
				add_window(len, STY_SMALL);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sample_queue.size() > 0 || req_valid)
			@(posedge clk);
		while (fits_expected.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests in %0d windows (%0d single-sample, %0d overlong)",
			samples_accepted, windows_seen, zero_den_seen, too_long_seen);
		$display("%0d mismatches over %0d cycles", errors, cycle_count);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
